// ===== sv/vqcl_pkg.sv =====
// ----------------------------------------------------------------------------
// vqcl_pkg: shared definitions for the codebook learning block
// Widths, request codes, register map and the control structs that pass
// between the sequencer, the component lanes and the merge stage.
// ----------------------------------------------------------------------------
package vqcl_pkg;

  // Default codebook depth.
  localparam int VQCL_ENTRIES = 512;

  // Vector geometry and field widths.
  localparam int DIM     = 9;
  localparam int COMP_W  = 16;
  localparam int IDX_W   = 9;
  localparam int DIST_W  = 20;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int GRP_W   = SQ_W + 2;
  localparam int SUM_W   = SQ_W + 4;
  localparam int RATE_W  = 16;
  localparam int REQ_W   = 2;

  // Stream word layout.
  localparam int IN_BITS     = IDX_W + DIM * COMP_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = IDX_W + DIST_W + DIM * COMP_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_WORD_LO = IDX_W + DIST_W;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LEARNING_RATE = 1'b0;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd1638;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRAIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [SQ_W-1:0]   sq_t;

  // Per-cycle commands to every lane.
  typedef struct packed {
    logic rd_en;    // read the codeword component at the address
    logic ld_wr;    // write the input component at the address
    logic upd_mul;  // form learning_rate * |x - w| from the read data
    logic upd_wr;   // write the nudged component back
  } lane_ctrl_t;

  // Tag that travels alongside each scanned codeword.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } scan_tag_t;

endpackage

// ===== sv/vq_codebook_competitive_learning.sv =====
// ----------------------------------------------------------------------------
// vq_codebook_competitive_learning: codebook with winner-take-all learning
// Nine component lanes scan every codeword, a merge stage finds the nearest
// one and the lanes move it toward the input by the learning rate.
// ----------------------------------------------------------------------------
//
//  Port group   Direction  Carries
//  s_axis_*     in         request word: entry index and nine components
//  m_axis_*     out        result word: winner index, distance, nine components
//  APB (p*)     in/out     learning_rate register at byte address 0
//
//  A train word streams one codeword a cycle through the lane RAM read ports,
//  then through the adder tree, the winner read and write-back.
//  One word is worked on at a time; the next is accepted while the result
//  waits in the output register. Reset clears control state and sets the
//  learning rate to 1638; codebook contents are undefined until loaded.
//
// ----------------------------------------------------------------------------
module vq_codebook_competitive_learning #(
  parameter int ENTRIES = vqcl_pkg::VQCL_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vqcl_pkg::PADDR_W-1:0]     paddr,
  input  logic [vqcl_pkg::PDATA_W-1:0]     pwdata,
  output logic [vqcl_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  // Request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_index[8:0], comp_0..comp_8 (16 bits each), zero fill
  input  logic [vqcl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // req_type[1:0]
  input  logic [vqcl_pkg::REQ_W-1:0]       s_axis_tuser,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // winner_index[8:0], min_distance[28:9], word_0..word_8 (16 bits each), zero fill
  output logic [vqcl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import vqcl_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_RWAIT = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_DRAIN = 4'd5;
  localparam logic [3:0] ST_UMUL  = 4'd6;
  localparam logic [3:0] ST_UWR   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [RATE_W-1:0]   rate_q;
  logic [REQ_W-1:0]    req;
  logic [IDX_W-1:0]    idx_q;
  comp_t               x_q [DIM];
  logic                in_range;
  logic [XW-1:0]       idx_x;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       addr;
  lane_ctrl_t          ctrl;
  scan_tag_t           tag0, tag1_q, tag2_q;
  logic [AW-1:0]       idx1_q, idx2_q;
  comp_t               lane_rd [DIM];
  sq_t                 lane_sq [DIM];
  comp_t               lane_nw [DIM];
  logic                mrg_done;
  logic [SUM_W-1:0]    mrg_best;
  logic [AW-1:0]       mrg_win;
  logic [AW-1:0]       win_q;
  logic [XW-1:0]       win_x;
  logic [DIST_W-1:0]   dist_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic [DIST_W-1:0]   res_dist_q;
  comp_t               res_word_q [DIM];
  logic                out_free;
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_d;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                accept;
  logic                cfg_wr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_LEARNING_RATE);
  assign prdata = (paddr[2] == REG_LEARNING_RATE) ? PDATA_W'(rate_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_wr) begin
      rate_q <= pwdata[RATE_W-1:0];
    end
  end

  // Request capture.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign req           = s_axis_tuser;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= s_axis_tdata[IDX_W-1:0];
      for (int i = 0; i < DIM; i++) begin
        x_q[i] <= s_axis_tdata[IDX_W + COMP_W*i +: COMP_W];
      end
    end
  end

  assign in_range = (32'(idx_q) < 32'(ENTRIES));
  assign idx_x    = XW'(idx_q);
  assign win_x    = XW'(win_q);
  assign out_free = ~m_valid_q | m_axis_tready;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctrl    = '0;
    addr    = idx_x[AW-1:0];
    tag0    = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          unique case (req)
            REQ_LOAD:  state_d = ST_LOAD;
            REQ_TRAIN: state_d = ST_SCAN;
            REQ_READ:  state_d = ST_READ;
            REQ_NONE:  state_d = ST_IDLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        ctrl.ld_wr = in_range;
        state_d    = ST_OUT;
      end
      ST_READ: begin
        ctrl.rd_en = in_range;
        state_d    = in_range ? ST_RWAIT : ST_OUT;
      end
      ST_RWAIT: begin
        state_d = ST_OUT;
      end
      ST_SCAN: begin
        ctrl.rd_en = 1'b1;
        addr       = cnt_q;
        tag0.valid = 1'b1;
        tag0.first = (cnt_q == '0);
        tag0.last  = (cnt_q == AW'(ENTRIES - 1));
        cnt_d      = cnt_q + 1'b1;
        if (tag0.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        addr = mrg_win;
        if (mrg_done) begin
          ctrl.rd_en = 1'b1;
          state_d    = ST_UMUL;
        end
      end
      ST_UMUL: begin
        ctrl.upd_mul = 1'b1;
        state_d      = ST_UWR;
      end
      ST_UWR: begin
        ctrl.upd_wr = 1'b1;
        addr        = win_q;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      tag1_q  <= '0;
      tag2_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tag1_q  <= tag0;
      tag2_q  <= tag1_q;
    end
  end

  // Scan index follows the RAM read and the square register.
  always_ff @(posedge clk_i) begin
    idx1_q <= addr;
    idx2_q <= idx1_q;
  end

  // Component lanes.
  for (genvar i = 0; i < DIM; i++) begin : g_lane
    vqcl_lane #(
      .ENTRIES (ENTRIES)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .addr_i   (addr),
      .x_i      (x_q[i]),
      .rate_i   (rate_q),
      .rdata_o  (lane_rd[i]),
      .prod_o   (lane_sq[i]),
      .nudged_o (lane_nw[i])
    );
  end

  // Distance sum and winner search.
  vqcl_merge #(
    .ENTRIES (ENTRIES)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag2_q),
    .idx_i  (idx2_q),
    .sq_i   (lane_sq),
    .done_o (mrg_done),
    .best_o (mrg_best),
    .win_o  (mrg_win)
  );

  // Result assembly.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN && mrg_done) begin
      win_q  <= mrg_win;
      dist_q <= mrg_best[SUM_W-1:SUM_W-DIST_W];
    end
    case (state_q)
      ST_LOAD: begin
        res_idx_q  <= idx_q;
        res_dist_q <= '0;
        for (int i = 0; i < DIM; i++) begin
          res_word_q[i] <= in_range ? x_q[i] : '0;
        end
      end
      ST_READ: begin
        res_idx_q  <= idx_q;
        res_dist_q <= '0;
        for (int i = 0; i < DIM; i++) begin
          res_word_q[i] <= '0;
        end
      end
      ST_RWAIT: begin
        for (int i = 0; i < DIM; i++) begin
          res_word_q[i] <= lane_rd[i];
        end
      end
      ST_UWR: begin
        res_idx_q  <= win_x[IDX_W-1:0];
        res_dist_q <= dist_q;
        for (int i = 0; i < DIM; i++) begin
          res_word_q[i] <= lane_nw[i];
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Result word layout, zero filled above the last component.
  always_comb begin
    m_data_d                  = '0;
    m_data_d[IDX_W-1:0]       = res_idx_q;
    m_data_d[IDX_W +: DIST_W] = res_dist_q;
    for (int i = 0; i < DIM; i++) begin
      m_data_d[OUT_WORD_LO + COMP_W*i +: COMP_W] = res_word_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== sv/vqcl_ram.sv =====
// ----------------------------------------------------------------------------
// vqcl_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module vqcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write takes priority; a read updates the output register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/vqcl_lane.sv =====
// ----------------------------------------------------------------------------
// vqcl_lane: one codeword component lane
// Holds one component of every codeword, squares the difference to the
// input component during a scan and nudges the winner toward the input.
// ----------------------------------------------------------------------------
module vqcl_lane #(
  parameter int ENTRIES = vqcl_pkg::VQCL_ENTRIES
) (
  input  logic                       clk_i,
  input  vqcl_pkg::lane_ctrl_t       ctrl_i,
  input  logic [$clog2(ENTRIES)-1:0] addr_i,
  input  vqcl_pkg::comp_t            x_i,
  input  logic [15:0]                rate_i,
  output vqcl_pkg::comp_t            rdata_o,
  output vqcl_pkg::sq_t              prod_o,
  output vqcl_pkg::comp_t            nudged_o
);
  import vqcl_pkg::*;

  comp_t              w;
  comp_t              diff;
  comp_t              mul_b;
  logic               neg;
  comp_t              wdata;
  sq_t                prod_q;
  comp_t              w_q;
  logic               neg_q;
  logic [SQ_W:0]      down_sum;
  comp_t              step_up;
  comp_t              step_down;

  // Component storage for this lane.
  assign wdata = ctrl_i.ld_wr ? x_i : nudged_o;

  vqcl_ram #(
    .WIDTH (COMP_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ctrl_i.rd_en | ctrl_i.ld_wr | ctrl_i.upd_wr),
    .we_i    (ctrl_i.ld_wr | ctrl_i.upd_wr),
    .addr_i  (addr_i),
    .wdata_i (wdata),
    .rdata_o (w)
  );

  assign rdata_o = w;

  // Absolute difference; the one multiplier squares it during a scan and
  // scales it by the learning rate during an update.
  assign neg   = (x_i < w);
  assign diff  = neg ? (w - x_i) : (x_i - w);
  assign mul_b = ctrl_i.upd_mul ? rate_i : diff;

  always_ff @(posedge clk_i) begin
    prod_q <= sq_t'(diff) * sq_t'(mul_b);
    if (ctrl_i.upd_mul) begin
      w_q   <= w;
      neg_q <= neg;
    end
  end

  assign prod_o = prod_q;

  // Floored step: truncate upward moves, round magnitude up on downward moves.
  assign down_sum  = {1'b0, prod_q} + (SQ_W+1)'(16'hFFFF);
  assign step_up   = prod_q[SQ_W-1:COMP_W];
  assign step_down = down_sum[SQ_W-1:COMP_W];
  assign nudged_o  = neg_q ? (w_q - step_down) : (w_q + step_up);

endmodule

// ===== sv/vqcl_merge.sv =====
// ----------------------------------------------------------------------------
// vqcl_merge: distance sum and winner search
// Adds the nine lane squares in a two-level registered tree and keeps the
// smallest total seen in the scan, lowest index on a tie.
// ----------------------------------------------------------------------------
module vqcl_merge #(
  parameter int ENTRIES = vqcl_pkg::VQCL_ENTRIES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vqcl_pkg::scan_tag_t        tag_i,
  input  logic [$clog2(ENTRIES)-1:0] idx_i,
  input  vqcl_pkg::sq_t              sq_i [vqcl_pkg::DIM],
  output logic                       done_o,
  output logic [vqcl_pkg::SUM_W-1:0] best_o,
  output logic [$clog2(ENTRIES)-1:0] win_o
);
  import vqcl_pkg::*;

  localparam int AW   = $clog2(ENTRIES);
  localparam int NGRP = DIM / 3;

  logic [GRP_W-1:0] grp_d [NGRP];
  logic [GRP_W-1:0] grp_q [NGRP];
  scan_tag_t        a_tag_q;
  logic [AW-1:0]    a_idx_q;
  logic [SUM_W-1:0] tot_d;
  logic [SUM_W-1:0] tot_q;
  scan_tag_t        b_tag_q;
  logic [AW-1:0]    b_idx_q;
  logic [SUM_W-1:0] best_q;
  logic [AW-1:0]    win_q;
  logic             done_q;

  // First level: three groups of three squares.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = GRP_W'(sq_i[3*g]) + GRP_W'(sq_i[3*g+1]) + GRP_W'(sq_i[3*g+2]);
    end
  end

  // Second level: total distance.
  always_comb begin
    tot_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      tot_d = tot_d + SUM_W'(grp_q[g]);
    end
  end

  // Tag pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
      done_q  <= 1'b0;
    end else begin
      a_tag_q <= tag_i;
      b_tag_q <= a_tag_q;
      done_q  <= b_tag_q.valid & b_tag_q.last;
    end
  end

  // Sums and running minimum.
  always_ff @(posedge clk_i) begin
    grp_q   <= grp_d;
    a_idx_q <= idx_i;
    tot_q   <= tot_d;
    b_idx_q <= a_idx_q;
    if (b_tag_q.valid && (b_tag_q.first || (tot_q < best_q))) begin
      best_q <= tot_q;
      win_q  <= b_idx_q;
    end
  end

  assign done_o = done_q;
  assign best_o = best_q;
  assign win_o  = win_q;

endmodule

// ===== bench/vq_codebook_competitive_learning_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vq_codebook_competitive_learning_tb: self-checking bench for the codebook
// The bench loads the whole codebook, then mixes load, read and train words
// with unused request codes under random stalls on both streams. It sweeps
// the learning rate through several values. A scoreboard keeps its own copy
// of the codebook and of the rate. It predicts every result word and checks
// each one field by field.
// ----------------------------------------------------------------------------
module vq_codebook_competitive_learning_tb;
  import vqcl_pkg::*;

  localparam int NUM_ENTRIES = VQCL_ENTRIES;
  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  // Idle pause before a register write, longer than a train word takes.
  localparam int SETTLE_CYCLES = NUM_ENTRIES + 20;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 40;
  localparam int RANDOM_PER_PHASE = 155;
  localparam int CALM_ITEMS = 100;
  // Room for about 1150 words, the long hold-off and the settling pauses, several times over.
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam logic [PADDR_W-1:0] RATE_ADDR = PADDR_W'(4 * REG_LEARNING_RATE);

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [IDX_W-1:0] index;
    comp_t [DIM-1:0]  comp;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]  winner;
    logic [DIST_W-1:0] distance;
    comp_t [DIM-1:0]   word;
  } vq_result_t;

  // Scoreboard: its own codebook and rate, and the results still to come.
  class codebook_tracker;
    comp_t [DIM-1:0]   words [NUM_ENTRIES];
    logic [RATE_W-1:0] rate = RATE_RESET;
    vq_result_t        pending_results [$];
    int                mismatches = 0;
    int                n_load = 0;
    int                n_train = 0;
    int                n_read = 0;
    int                n_unused = 0;
    int                n_checked = 0;

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) begin
        $display("[%0t] MISMATCH: %s", $realtime, what);
      end
    endtask

    // Work out the result of one accepted request word.
    function void note_request(input request_t r);
      vq_result_t exp_res;
      logic [63:0] best, acc, delta, rate64, diff64, step;
      comp_t w, x;
      int win;
      exp_res = '0;
      best = '0;
      win = 0;
      case (r.kind) inside
        REQ_LOAD, REQ_READ: begin
          exp_res.winner = r.index;
          if (int'(r.index) < NUM_ENTRIES) begin
            if (r.kind == REQ_LOAD) begin
              words[r.index] = r.comp;
              n_load++;
            end else begin
              n_read++;
            end
            exp_res.word = words[r.index];
          end
          pending_results.push_back(exp_res);
        end
        REQ_TRAIN: begin
          // Exhaustive nearest search; ties keep the lowest index.
          for (int k = 0; k < NUM_ENTRIES; k++) begin
            acc = '0;
            for (int i = 0; i < DIM; i++) begin
              w = words[k][i];
              x = r.comp[i];
              delta = (x >= w) ? {48'b0, comp_t'(x - w)} : {48'b0, comp_t'(w - x)};
              acc += delta * delta;
            end
            if (k == 0 || acc < best) begin
              best = acc;
              win = k;
            end
          end
          // Move the winner toward the input, flooring toward minus infinity.
          rate64 = {48'b0, rate};
          for (int i = 0; i < DIM; i++) begin
            w = words[win][i];
            x = r.comp[i];
            if (x >= w) begin
              diff64 = {48'b0, comp_t'(x - w)};
              step = (rate64 * diff64) >> 16;
              words[win][i] = w + step[COMP_W-1:0];
            end else begin
              diff64 = {48'b0, comp_t'(w - x)};
              step = (rate64 * diff64 + 64'd65535) >> 16;
              words[win][i] = w - step[COMP_W-1:0];
            end
          end
          exp_res.winner = IDX_W'(win);
          exp_res.distance = DIST_W'(best >> 16);
          exp_res.word = words[win];
          n_train++;
          pending_results.push_back(exp_res);
        end
        default: n_unused++;
      endcase
    endfunction

    // Compare one accepted result word with the oldest expectation.
    task check_result(input logic [OUT_DATA_W-1:0] data);
      vq_result_t got, exp_res;
      got.winner = data[IDX_W-1:0];
      got.distance = data[IDX_W +: DIST_W];
      for (int i = 0; i < DIM; i++) begin
        got.word[i] = data[OUT_WORD_LO + COMP_W * i +: COMP_W];
      end
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, winner_index %0d",
                                  got.winner));
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (got.winner !== exp_res.winner) begin
          report_mismatch($sformatf("result %0d winner_index got %0d expected %0d",
                                    n_checked, got.winner, exp_res.winner));
        end
        if (got.distance !== exp_res.distance) begin
          report_mismatch($sformatf("result %0d min_distance got %0d expected %0d",
                                    n_checked, got.distance, exp_res.distance));
        end
        for (int i = 0; i < DIM; i++) begin
          if (got.word[i] !== exp_res.word[i]) begin
            report_mismatch($sformatf("result %0d word_%0d got %h expected %h",
                                      n_checked, i, got.word[i], exp_res.word[i]));
          end
        end
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  codebook_tracker tracker;
  int unsigned     cycle_count = 0;
  int              results_seen = 0;
  int              src_gap_pct = 0;
  int              sink_stall_pct = 0;
  bit              calm = 1'b0;
  bit              held_off = 1'b0;

  vq_codebook_competitive_learning #(
    .ENTRIES(NUM_ENTRIES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("vq_codebook_competitive_learning test failed");
      $finish;
    end
  end

  // Result monitor: a word seen at the falling edge moves at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      results_seen++;
      tracker.check_result(m_axis_tdata);
    end
  end

  // Result receiver: one long hold-off early on, then random stall bursts.
  initial begin
    m_axis_tready = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && int'($urandom_range(0, 99)) < sink_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one request word and note it once it is taken.
  task automatic push_request(input request_t r);
    logic [IN_DATA_W-1:0] data;
    data = '0;
    data[IDX_W-1:0] = r.index;
    for (int i = 0; i < DIM; i++) begin
      data[IDX_W + COMP_W * i +: COMP_W] = r.comp[i];
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= r.kind;
    @(negedge clk_i);
    while (s_axis_tready !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_request(r);
    if (!calm && int'($urandom_range(0, 99)) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every result and let the block go idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the learning rate, then read it back.
  task automatic set_rate(input logic [RATE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RATE_ADDR;
    pwdata <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tracker.rate = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== PDATA_W'(value)) begin
      tracker.report_mismatch($sformatf("learning_rate read back %h expected %h",
                                        prdata, value));
    end
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic request_t uniform_request(input logic [REQ_W-1:0] kind,
                                               input logic [IDX_W-1:0] index,
                                               input comp_t value);
    request_t r;
    r.kind = kind;
    r.index = index;
    for (int i = 0; i < DIM; i++) r.comp[i] = value;
    return r;
  endfunction

  // Random request: mostly trains near a stored codeword, plus loads, reads
  // and a few unused request codes. The codebook fill also draws its components here.
  function automatic request_t random_request();
    request_t r;
    int unsigned roll, k;
    int v;
    r.index = IDX_W'($urandom);
    for (int i = 0; i < DIM; i++) r.comp[i] = comp_t'($urandom);
    roll = $urandom_range(0, 99);
    k = $urandom_range(0, NUM_ENTRIES - 1);
    if (roll < 6) begin
      r.kind = REQ_NONE;
    end else if (roll < 54) begin
      r.kind = REQ_TRAIN;
      if (roll < 40) begin
        for (int i = 0; i < DIM; i++) begin
          v = int'(tracker.words[k][i]) + int'($urandom_range(0, 2048)) - 1024;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          r.comp[i] = comp_t'(v);
        end
      end else if (roll >= 48) begin
        for (int i = 0; i < DIM; i++) r.comp[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
    end else if (roll < 76) begin
      r.kind = REQ_LOAD;
      if ($urandom_range(0, 1)) begin
        // Pixel-like codeword with zero fraction.
        for (int i = 0; i < DIM; i++) r.comp[i] = {8'($urandom), 8'h00};
      end
    end else begin
      r.kind = REQ_READ;
    end
    return r;
  endfunction

  // Stimulus and end of run.
  initial begin
    request_t r;
    logic [RATE_W-1:0] phase_rates [4];
    logic [RATE_W-1:0] mid_rate;
    int counted;
    tracker = new;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_NONE;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme indexes and values, read-back, an unused code.
    push_request(uniform_request(REQ_LOAD, 9'd0, 16'h0000));
    push_request(uniform_request(REQ_LOAD, 9'd511, 16'hFFFF));
    push_request(uniform_request(REQ_READ, 9'd0, 16'hFFFF));
    push_request(uniform_request(REQ_READ, 9'd511, 16'h0000));
    push_request(uniform_request(REQ_NONE, 9'd511, 16'hFFFF));
    r = uniform_request(REQ_LOAD, 9'h155, 16'h5555);
    for (int i = 1; i < DIM; i += 2) r.comp[i] = 16'hAAAA;
    push_request(r);
    push_request(uniform_request(REQ_READ, 9'h155, 16'h0000));

    // Fill the whole codebook back to back so the long hold-off backs it up.
    sink_stall_pct = 10;
    for (int idx = 0; idx < NUM_ENTRIES; idx++) begin
      r = random_request();
      r.kind = REQ_LOAD;
      r.index = IDX_W'(idx);
      push_request(r);
    end

    // Directed trains at the reset rate: a tied pair, extremes, read-back.
    src_gap_pct = 20;
    push_request(uniform_request(REQ_LOAD, 9'd9, 16'h4280));
    push_request(uniform_request(REQ_LOAD, 9'd5, 16'h4280));
    push_request(uniform_request(REQ_TRAIN, 9'd9, 16'h4280));
    r = uniform_request(REQ_TRAIN, 9'd0, 16'h4280);
    r.comp[0] = 16'h4281;
    push_request(r);
    push_request(uniform_request(REQ_TRAIN, 9'd0, 16'h0000));
    push_request(uniform_request(REQ_TRAIN, 9'd511, 16'hFFFF));
    r = uniform_request(REQ_TRAIN, 9'h0AA, 16'hAAAA);
    for (int i = 1; i < DIM; i += 2) r.comp[i] = 16'h5555;
    push_request(r);
    push_request(uniform_request(REQ_READ, 9'd5, 16'h0000));
    push_request(uniform_request(REQ_READ, 9'd9, 16'h0000));
    push_request(uniform_request(REQ_NONE, 9'd0, 16'h0000));

    // Random phases, one learning rate each.
    mid_rate = RATE_W'($urandom_range(1, 65534));
    phase_rates[0] = 16'hFFFF;
    phase_rates[1] = 16'h0000;
    phase_rates[2] = mid_rate;
    phase_rates[3] = 16'h8000;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      set_rate(phase_rates[ph]);
      case ($urandom_range(0, 2))
        0: src_gap_pct = 0;
        1: src_gap_pct = 10;
        default: src_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: sink_stall_pct = 0;
        1: sink_stall_pct = 8;
        default: sink_stall_pct = 30;
      endcase
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        if (ph == 3 && counted >= RANDOM_PER_PHASE - CALM_ITEMS) calm = 1'b1;
        r = random_request();
        push_request(r);
        if (r.kind != REQ_NONE) counted++;
      end
    end
    settle();

    $display("Run covered %0d loads, %0d trains, %0d reads and %0d unused codes;",
             tracker.n_load, tracker.n_train, tracker.n_read, tracker.n_unused);
    $display("%0d results checked at rates reset, 65535, 0, %0d and 32768, %0d-cycle hold-off.",
             tracker.n_checked, mid_rate, HOLD_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("vq_codebook_competitive_learning test passed");
    end else begin
      $display("vq_codebook_competitive_learning test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/vqcl_pkg.sv
sv/vqcl_ram.sv
sv/vqcl_lane.sv
sv/vqcl_merge.sv
sv/vq_codebook_competitive_learning.sv
bench/vq_codebook_competitive_learning_tb.sv
